>>> src/dis_pdu_stream_parser_defines.svh
// assertion macros shared by the parser modules
// depends on nothing
`ifndef DIS_PDU_STREAM_PARSER_DEFINES_SVH
`define DIS_PDU_STREAM_PARSER_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define DPP_ASSERT_IMP(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed");
// next-cycle implication checked outside reset
`define DPP_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed");
`endif

>>> src/dpp_pkg.sv
// shared types and constants of the pdu stream parser
// depends on nothing
`timescale 1ns / 1ps
package dpp_pkg;
   typedef enum logic [2:0] {
      KIND_NONE = 3'd0, KIND_FIRE = 3'd1, KIND_DET = 3'd2,
      KIND_EMIS = 3'd3, KIND_SIG = 3'd4, KIND_TX = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK = 3'd0, ST_HDR_SHORT = 3'd1, ST_VERSION = 3'd2,
      ST_UNKNOWN = 3'd3, ST_LENGTH = 3'd4, ST_BODY_SHORT = 3'd5
   } status_type;

   localparam logic [5:0] ID_TRACK = 6'd27;
   localparam logic [5:0] ID_SIGBYTE = 6'd30;

   // one result item
   typedef struct packed {
      logic [5:0]  field_id;
      logic [63:0] field_value;
      logic        is_status;
      logic [2:0]  status_code;
      logic        last;
   } result_type;

   // fixed body field table lookup: hit, id, size in bytes
   typedef struct packed {
      logic       hit;
      logic [5:0] id;
      logic [3:0] size;
   } fdesc_type;

   function automatic fdesc_type fdesc_lookup(kind_type kind, logic [15:0] off);
      fdesc_type d;
      d = '{hit: 1'b0, id: 6'd0, size: 4'd0};
      case (kind)
         KIND_FIRE: begin
            case (off)
               16'd17: d = '{1'b1, 6'd0, 4'd2};
               16'd23: d = '{1'b1, 6'd1, 4'd2};
               16'd29: d = '{1'b1, 6'd2, 4'd2};
               16'd35: d = '{1'b1, 6'd3, 4'd2};
               16'd47: d = '{1'b1, 6'd4, 4'd8};
               16'd55: d = '{1'b1, 6'd5, 4'd8};
               16'd63: d = '{1'b1, 6'd6, 4'd8};
               16'd68: d = '{1'b1, 6'd7, 4'd1};
               16'd73: d = '{1'b1, 6'd8, 4'd2};
               16'd75: d = '{1'b1, 6'd9, 4'd2};
               16'd77: d = '{1'b1, 6'd10, 4'd2};
               16'd79: d = '{1'b1, 6'd11, 4'd2};
               16'd83: d = '{1'b1, 6'd12, 4'd4};
               16'd87: d = '{1'b1, 6'd13, 4'd4};
               16'd91: d = '{1'b1, 6'd14, 4'd4};
               16'd95: d = '{1'b1, 6'd15, 4'd4};
               default: d = d;
            endcase
         end
         KIND_DET: begin
            case (off)
               16'd17: d = '{1'b1, 6'd0, 4'd2};
               16'd23: d = '{1'b1, 6'd1, 4'd2};
               16'd29: d = '{1'b1, 6'd2, 4'd2};
               16'd35: d = '{1'b1, 6'd3, 4'd2};
               16'd39: d = '{1'b1, 6'd12, 4'd4};
               16'd43: d = '{1'b1, 6'd13, 4'd4};
               16'd47: d = '{1'b1, 6'd14, 4'd4};
               16'd55: d = '{1'b1, 6'd4, 4'd8};
               16'd63: d = '{1'b1, 6'd5, 4'd8};
               16'd71: d = '{1'b1, 6'd6, 4'd8};
               16'd76: d = '{1'b1, 6'd7, 4'd1};
               16'd81: d = '{1'b1, 6'd8, 4'd2};
               16'd83: d = '{1'b1, 6'd9, 4'd2};
               16'd85: d = '{1'b1, 6'd10, 4'd2};
               16'd87: d = '{1'b1, 6'd11, 4'd2};
               16'd100: d = '{1'b1, 6'd16, 4'd1};
               default: d = d;
            endcase
         end
         KIND_EMIS: begin
            case (off)
               16'd17: d = '{1'b1, 6'd17, 4'd2};
               16'd33: d = '{1'b1, 6'd18, 4'd2};
               16'd34: d = '{1'b1, 6'd19, 4'd1};
               16'd55: d = '{1'b1, 6'd20, 4'd4};
               16'd59: d = '{1'b1, 6'd21, 4'd4};
               16'd63: d = '{1'b1, 6'd22, 4'd4};
               16'd67: d = '{1'b1, 6'd23, 4'd4};
               16'd71: d = '{1'b1, 6'd24, 4'd4};
               16'd75: d = '{1'b1, 6'd25, 4'd4};
               16'd92: d = '{1'b1, 6'd26, 4'd1};
               default: d = d;
            endcase
         end
         KIND_SIG: begin
            case (off)
               16'd17: d = '{1'b1, 6'd28, 4'd2};
               16'd19: d = '{1'b1, 6'd29, 4'd2};
               default: d = d;
            endcase
         end
         KIND_TX: begin
            case (off)
               16'd17: d = '{1'b1, 6'd28, 4'd2};
               16'd19: d = '{1'b1, 6'd29, 4'd2};
               16'd28: d = '{1'b1, 6'd31, 4'd1};
               16'd39: d = '{1'b1, 6'd32, 4'd8};
               16'd47: d = '{1'b1, 6'd33, 4'd8};
               16'd55: d = '{1'b1, 6'd34, 4'd8};
               16'd79: d = '{1'b1, 6'd35, 4'd8};
               16'd83: d = '{1'b1, 6'd36, 4'd4};
               16'd87: d = '{1'b1, 6'd37, 4'd4};
               default: d = d;
            endcase
         end
         default: d = d;
      endcase
      return d;
   endfunction
endpackage

>>> src/dpp_decode.sv
// per-byte parser: frame state and combinational field extraction
// depends on dpp_pkg and the shared assertion macros
`timescale 1ns / 1ps
`include "dis_pdu_stream_parser_defines.svh"
module dpp_decode (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [7:0]             data_byte,
   input  logic                   frame_end,
   output logic                   field_hit,
   output dpp_pkg::result_type    field_res,
   output logic                   status_hit,
   output dpp_pkg::result_type    status_res
);
   logic [15:0]       byte_index_ff, byte_index_in;
   dpp_pkg::kind_type frame_kind_ff, frame_kind_in;
   logic [15:0]       declared_length_ff, declared_length_in;
   logic [63:0]       field_shift_ff, field_shift_in;
   logic [7:0]        track_count_ff, track_count_in;
   logic [12:0]       payload_bytes_ff, payload_bytes_in;
   logic [2:0]        fault_code_ff, fault_code_in;

   dpp_pkg::fdesc_type fd;
   dpp_pkg::kind_type  kind_now;
   logic [15:0] rel;
   logic [16:0] got;
   logic [16:0] needed;
   logic [63:0] mask;
   logic [2:0]  st;

   // next state and field selection
   always_comb begin
      field_shift_in     = {field_shift_ff[55:0], data_byte};
      fault_code_in      = fault_code_ff;
      frame_kind_in      = frame_kind_ff;
      declared_length_in = declared_length_ff;
      track_count_in     = track_count_ff;
      payload_bytes_in   = payload_bytes_ff;
      if (byte_index_ff == 16'd0 && data_byte == 8'd0) fault_code_in = 3'(dpp_pkg::ST_VERSION);
      if (byte_index_ff == 16'd3 && fault_code_in == 3'd0) begin
         unique case (field_shift_in[15:0])
            16'h0202: frame_kind_in = dpp_pkg::KIND_FIRE;
            16'h0302: frame_kind_in = dpp_pkg::KIND_DET;
            16'h1706: frame_kind_in = dpp_pkg::KIND_EMIS;
            16'h1A04: frame_kind_in = dpp_pkg::KIND_SIG;
            16'h1904: frame_kind_in = dpp_pkg::KIND_TX;
            default:  frame_kind_in = dpp_pkg::KIND_NONE;
         endcase
         if (frame_kind_in == dpp_pkg::KIND_NONE) fault_code_in = 3'(dpp_pkg::ST_UNKNOWN);
      end
      if (byte_index_ff == 16'd9) declared_length_in = field_shift_in[15:0];
      kind_now = frame_kind_in;

      // table lookup and masking by field size
      fd   = dpp_pkg::fdesc_lookup(kind_now, byte_index_ff);
      mask = (fd.size[3]) ? '1 : ((64'd1 << {fd.size[2:0], 3'b000}) - 64'd1);
      field_hit = 1'b0;
      field_res = '0;
      rel = byte_index_ff - 16'd100;
      if (fd.hit) begin
         field_hit = 1'b1;
         field_res.field_id    = fd.id;
         field_res.field_value = field_shift_in & mask;
      end
      if (kind_now == dpp_pkg::KIND_EMIS) begin
         if (byte_index_ff == 16'd93) track_count_in = data_byte;
         if (byte_index_ff >= 16'd100 && rel[2:0] == 3'd5
             && rel[15:3] < {5'd0, track_count_in}) begin
            field_hit = 1'b1;
            field_res.field_id    = dpp_pkg::ID_TRACK;
            field_res.field_value = {48'd0, field_shift_in[15:0]};
         end
      end
      if (kind_now == dpp_pkg::KIND_SIG) begin
         if (byte_index_ff == 16'd29) payload_bytes_in = field_shift_in[15:3];
         if (byte_index_ff >= 16'd32
             && {1'b0, byte_index_ff} < 17'd32 + {4'd0, payload_bytes_in}) begin
            field_hit = 1'b1;
            field_res.field_id    = dpp_pkg::ID_SIGBYTE;
            field_res.field_value = {56'd0, data_byte};
         end
      end

      // end-of-frame status
      got = {1'b0, byte_index_ff} + 17'd1;
      case (kind_now)
         dpp_pkg::KIND_FIRE: needed = 17'd96;
         dpp_pkg::KIND_DET:  needed = 17'd104;
         dpp_pkg::KIND_EMIS: needed = 17'd100 + {6'd0, track_count_in, 3'd0};
         dpp_pkg::KIND_SIG:  needed = 17'd32 + {4'd0, payload_bytes_in};
         dpp_pkg::KIND_TX:   needed = 17'd104;
         default:            needed = 17'd0;
      endcase
      if (got < 17'd12) st = 3'(dpp_pkg::ST_HDR_SHORT);
      else if (fault_code_in != 3'd0) st = fault_code_in;
      else if (byte_index_ff == 16'hFFFF || got != {1'b0, declared_length_in})
         st = 3'(dpp_pkg::ST_LENGTH);
      else if (got < needed) st = 3'(dpp_pkg::ST_BODY_SHORT);
      else st = 3'(dpp_pkg::ST_OK);
      status_hit = frame_end;
      status_res = '{field_id: 6'd0, field_value: 64'd0, is_status: 1'b1,
                     status_code: st, last: 1'b1};

      byte_index_in = byte_index_ff;
      if (frame_end) begin
         byte_index_in = '0; frame_kind_in = dpp_pkg::KIND_NONE; declared_length_in = '0;
         field_shift_in = '0; track_count_in = '0; payload_bytes_in = '0; fault_code_in = '0;
      end else if (byte_index_ff != 16'hFFFF) begin
         byte_index_in = byte_index_ff + 16'd1;
      end
   end

   // frame state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff <= '0; frame_kind_ff <= dpp_pkg::KIND_NONE;
         declared_length_ff <= '0; field_shift_ff <= '0; track_count_ff <= '0;
         payload_bytes_ff <= '0; fault_code_ff <= '0;
      end else if (step) begin
         byte_index_ff <= byte_index_in; frame_kind_ff <= frame_kind_in;
         declared_length_ff <= declared_length_in; field_shift_ff <= field_shift_in;
         track_count_ff <= track_count_in; payload_bytes_ff <= payload_bytes_in;
         fault_code_ff <= fault_code_in;
      end
   end

   `DPP_ASSERT_NEXT(a_end_clears, clock, reset, step && frame_end, byte_index_ff == 16'd0)
   `DPP_ASSERT_IMP(a_kind_fault, clock, reset,
      frame_kind_ff != dpp_pkg::KIND_NONE, fault_code_ff == 3'd0)
   `DPP_ASSERT_IMP(a_no_body_early, clock, reset, byte_index_ff < 16'd12, !field_hit)
endmodule

>>> src/dis_pdu_stream_parser.sv
// DIS PDU stream parser: takes PDU bytes and returns extracted fields and
// a status item per frame. An accepted byte is decoded in the same cycle and its results
// (none, one or two) enter a two-slot output buffer; a new byte is taken only when both
// slots will be free after this cycle's pop, so one byte per cycle is taken only while
// each result is popped as soon as it is held; a frame's final byte with a field yields two results.
// depends on dpp_pkg, dpp_decode and the shared assertion macros
`timescale 1ns / 1ps
`include "dis_pdu_stream_parser_defines.svh"
module dis_pdu_stream_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tlast,   // frame_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // field_id[5:0], field_value[69:6], zero pad
   output logic [3:0]  rsp_tuser,   // is_status[0], status_code[3:1]
   output logic        rsp_tlast    // last
);
   logic               step;
   logic               field_hit, status_hit;
   dpp_pkg::result_type field_res, status_res;
   dpp_pkg::result_type slot_ff [2];
   logic [1:0]         count_ff, count_in;
   dpp_pkg::result_type slot_in [2];
   logic [1:0]         pop, nres;
   logic [1:0]         base;

   dpp_decode u_decode (
      .clock, .reset, .step, .data_byte(req_tdata), .frame_end(req_tlast),
      .field_hit, .field_res, .status_hit, .status_res
   );

   // accept while two slots will be free after this cycle's pop
   assign pop        = {1'b0, rsp_tvalid & rsp_tready};
   assign req_tready = (count_ff - pop) == 2'd0;
   assign step       = req_tvalid & req_tready;
   assign nres       = {1'b0, field_hit} + {1'b0, status_hit};

   // output buffer update
   always_comb begin
      slot_in[0] = slot_ff[0];
      slot_in[1] = slot_ff[1];
      if (pop[0]) slot_in[0] = slot_ff[1];
      base = count_ff - pop;
      count_in = base;
      if (step) begin
         if (field_hit) begin
            slot_in[0] = field_res;
            if (status_hit) slot_in[1] = status_res;
         end else if (status_hit) begin
            slot_in[0] = status_res;
         end
         count_in = nres;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else count_ff <= count_in;
      slot_ff[0] <= slot_in[0];
      slot_ff[1] <= slot_in[1];
   end

   // result port
   assign rsp_tvalid = count_ff != 2'd0;
   assign rsp_tdata  = {2'b00, slot_ff[0].field_value, slot_ff[0].field_id};
   assign rsp_tuser  = {slot_ff[0].status_code, slot_ff[0].is_status};
   assign rsp_tlast  = slot_ff[0].last;

   `DPP_ASSERT_IMP(a_count_range, clock, reset, 1'b1, count_ff != 2'd3)
   `DPP_ASSERT_IMP(a_ready_empty, clock, reset, req_tready, count_ff - pop == 2'd0)
   `DPP_ASSERT_IMP(a_last_status, clock, reset, rsp_tvalid && rsp_tlast, rsp_tuser[0])
endmodule

>>> bench/tb_dis_pdu_stream_parser.sv
// testbench for the pdu stream parser: byte frames in, field and status items out
// depends on dpp_pkg and dis_pdu_stream_parser
`timescale 1ns / 1ps
module tb_dis_pdu_stream_parser;
   import dpp_pkg::*;

   // expected output store and checker
   class pdu_scoreboard;
      result_type pending[$];
      int mismatches;
      int checked;
      logic [15:0] offset;
      kind_type kind;
      logic [15:0] length;
      logic [63:0] shreg;
      logic [7:0] tracks;
      logic [12:0] sig_bytes;
      logic [2:0] fault;

      function void clear();
         offset = 0; kind = KIND_NONE; length = 0; shreg = 0;
         tracks = 0; sig_bytes = 0; fault = 0;
      endfunction

      function kind_type pair_kind(logic [15:0] tf);
         case (tf)
            16'h0202: return KIND_FIRE;
            16'h0302: return KIND_DET;
            16'h1706: return KIND_EMIS;
            16'h1A04: return KIND_SIG;
            16'h1904: return KIND_TX;
            default:  return KIND_NONE;
         endcase
      endfunction

      // fixed body field position: returns size in bytes, 0 if none
      function int body_field(kind_type k, int o, output logic [5:0] id);
         int t[$];
         int i;
         id = 0;
         case (k)
            KIND_FIRE: t = '{17,2,0, 23,2,1, 29,2,2, 35,2,3, 47,8,4, 55,8,5, 63,8,6,
                             68,1,7, 73,2,8, 75,2,9, 77,2,10, 79,2,11, 83,4,12,
                             87,4,13, 91,4,14, 95,4,15};
            KIND_DET:  t = '{17,2,0, 23,2,1, 29,2,2, 35,2,3, 39,4,12, 43,4,13,
                             47,4,14, 55,8,4, 63,8,5, 71,8,6, 76,1,7, 81,2,8,
                             83,2,9, 85,2,10, 87,2,11, 100,1,16};
            KIND_EMIS: t = '{17,2,17, 33,2,18, 34,1,19, 55,4,20, 59,4,21, 63,4,22,
                             67,4,23, 71,4,24, 75,4,25, 92,1,26};
            KIND_SIG:  t = '{17,2,28, 19,2,29};
            KIND_TX:   t = '{17,2,28, 19,2,29, 28,1,31, 39,8,32, 47,8,33, 55,8,34,
                             79,8,35, 83,4,36, 87,4,37};
            default: ;
         endcase
         for (i = 0; i < t.size(); i += 3)
            if (t[i] == o) begin
               id = t[i+2];
               return t[i+1];
            end
         return 0;
      endfunction

      // append one expectation at the tail
      function void add_expected(result_type r);
         pending = {pending, r};
      endfunction

      function void push_field(logic [5:0] id, logic [63:0] v);
         result_type r;
         r = '0;
         r.field_id = id;
         r.field_value = v;
         add_expected(r);
      endfunction

      // note one accepted request byte
      function void note_request(logic [7:0] b, logic fend);
         int o;
         int sz;
         int need;
         int got;
         logic [5:0] id;
         result_type r;
         o = offset;
         shreg = {shreg[55:0], b};
         if (o == 0 && b == 0) fault = ST_VERSION;
         if (o == 3 && fault == 0) begin
            kind = pair_kind(shreg[15:0]);
            if (kind == KIND_NONE) fault = ST_UNKNOWN;
         end
         if (o == 9) length = shreg[15:0];
         if (kind != KIND_NONE) begin
            sz = body_field(kind, o, id);
            if (sz != 0)
               push_field(id, sz >= 8 ? shreg : shreg & ((64'd1 << (8 * sz)) - 1));
            if (kind == KIND_EMIS) begin
               if (o == 93) tracks = b;
               if (o >= 100 && ((o - 100) & 7) == 5 && ((o - 100) >> 3) < tracks)
                  push_field(ID_TRACK, shreg[15:0]);
            end
            if (kind == KIND_SIG) begin
               if (o == 29) sig_bytes = shreg[15:3];
               if (o >= 32 && o < 32 + sig_bytes) push_field(ID_SIGBYTE, b);
            end
         end
         if (fend) begin
            got = o + 1;
            case (kind)
               KIND_FIRE: need = 96;
               KIND_DET:  need = 104;
               KIND_EMIS: need = 100 + 8 * tracks;
               KIND_SIG:  need = 32 + sig_bytes;
               KIND_TX:   need = 104;
               default:   need = 0;
            endcase
            r = '0;
            r.is_status = 1;
            r.last = 1;
            if (got < 12) r.status_code = ST_HDR_SHORT;
            else if (fault != 0) r.status_code = fault;
            else if (o == 16'hFFFF || got != length) r.status_code = ST_LENGTH;
            else if (got < need) r.status_code = ST_BODY_SHORT;
            else r.status_code = ST_OK;
            add_expected(r);
            clear();
         end else if (offset != 16'hFFFF) begin
            offset++;
         end
      endfunction

      // compare one accepted result with the oldest expectation
      function void check_result(result_type got);
         result_type exp;
         checked++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", got);
            return;
         end
         exp = pending.pop_front();
         if (got !== exp) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: id %0d/%0d value %h/%h status %b%0d/%b%0d last %b/%b",
                  exp.field_id, got.field_id, exp.field_value, got.field_value,
                  exp.is_status, exp.status_code, got.is_status, got.status_code,
                  exp.last, got.last);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [7:0] req_tdata = 0;
   logic req_tlast = 0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [71:0] rsp_tdata;
   logic [3:0] rsp_tuser;
   logic rsp_tlast;

   pdu_scoreboard sb = new();
   int bytes_sent;
   int frames_sent;
   int idle_cycles;
   bit hold_off;
   int burst_left;

   always #6 clock = ~clock;

   dis_pdu_stream_parser dut (.*);

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // result monitor
   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result('{rsp_tdata[5:0], rsp_tdata[69:6], rsp_tuser[0],
            rsp_tuser[3:1], rsp_tlast});

   // receiver: own stall pattern, plus one long hold-off window
   initial begin
      int n;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off) rsp_tready <= 0;
         else begin
            n = $urandom_range(0, 15);
            rsp_tready <= (n < 10) || (n == 15 && ($urandom & 1));
         end
      end
   end

   // send one request byte, with bursty gaps
   task send_byte(input logic [7:0] b, input logic fend);
      int g;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         if ($urandom_range(0, 2) != 0) begin
            g = $urandom_range(1, 6);
            req_tvalid <= 0;
            repeat (g) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1;
      req_tdata <= b;
      req_tlast <= fend;
      do @(posedge clock); while (!req_tready);
      sb.note_request(b, fend);
      bytes_sent++;
      if (fend) frames_sent++;
   endtask

   // build a frame; mode 0 good, 1 random noise, 2 broken header/length
   task send_frame(input kind_type k, input int len, input int mode, input int tracks);
      logic [7:0] f[];
      int i;
      f = new[len];
      for (i = 0; i < len; i++) f[i] = $urandom;
      if (mode != 1) begin
         if (len > 0 && f[0] == 0) f[0] = 8'd6;
         if (len > 3) begin
            case (k)
               KIND_FIRE: {f[2], f[3]} = 16'h0202;
               KIND_DET:  {f[2], f[3]} = 16'h0302;
               KIND_EMIS: {f[2], f[3]} = 16'h1706;
               KIND_SIG:  {f[2], f[3]} = 16'h1A04;
               default:   {f[2], f[3]} = 16'h1904;
            endcase
         end
         if (len > 9) {f[8], f[9]} = (mode == 2 && $urandom_range(0, 1)) ?
            16'($urandom) : 16'(len);
         if (k == KIND_EMIS && len > 93) f[93] = tracks;
         if (k == KIND_SIG && len > 29) {f[28], f[29]} = 16'(tracks * 8 + $urandom_range(0, 7));
         if (mode == 2 && len > 0 && $urandom_range(0, 3) == 0) f[0] = 0;
      end
      for (i = 0; i < len; i++) send_byte(f[i], i == len - 1);
   endtask

   task wait_drained();
      req_tvalid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   function int kind_len(kind_type k, int tracks);
      case (k)
         KIND_FIRE: return 96;
         KIND_DET:  return 104;
         KIND_EMIS: return 100 + 8 * tracks;
         KIND_SIG:  return 32 + tracks;
         default:   return 104;
      endcase
   endfunction

   initial begin
      kind_type k;
      int t;
      int len;
      int m;
      sb.clear();
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed frames: each kind, faults and size extremes
      send_frame(KIND_FIRE, 96, 0, 0);
      send_frame(KIND_DET, 104, 0, 0);
      send_frame(KIND_EMIS, 100 + 16, 0, 2);
      send_frame(KIND_SIG, 32 + 5, 0, 5);
      send_frame(KIND_TX, 104, 0, 0);
      send_frame(KIND_TX, 1, 1, 0);            // header short
      send_frame(KIND_FIRE, 11, 0, 0);
      send_frame(KIND_FIRE, 60, 0, 0);          // body short
      send_frame(KIND_EMIS, 100, 0, 255);       // tracks declared but missing
      send_frame(KIND_FIRE, 120, 0, 0);         // trailing bytes
      send_frame(KIND_NONE, 20, 1, 0);          // noise, likely unknown type
      send_byte(8'h00, 0);                      // version zero then all-ones bytes
      repeat (14) send_byte(8'hFF, 0);
      send_byte(8'hFF, 1);
      wait_drained();

      // long receiver hold-off while requests keep coming
      hold_off = 1;
      fork
         send_frame(KIND_SIG, 32 + 40, 0, 40);
         begin repeat (300) @(posedge clock); hold_off = 0; end
      join
      wait_drained();

      // random frames, mostly well formed
      while (bytes_sent < 1650) begin
         k = kind_type'($urandom_range(1, 5));
         t = $urandom_range(0, 3);
         len = kind_len(k, k == KIND_SIG ? t * 4 : t);
         m = $urandom_range(0, 9);
         if (m < 7) send_frame(k, len, 0, k == KIND_SIG ? t * 4 : t);
         else if (m == 7) send_frame(k, $urandom_range(1, 40), 1, 0);
         else send_frame(k, $urandom_range(8, len + 8), 2, k == KIND_SIG ? t * 4 : t);
      end
      wait_drained();

      $display("covered %0d request bytes in %0d frames, %0d results checked",
         bytes_sent, frames_sent, sb.checked);
      if (sb.mismatches == 0 && sb.pending.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule

>>> files.f
+incdir+src
src/dpp_pkg.sv
src/dpp_decode.sv
src/dis_pdu_stream_parser.sv
bench/tb_dis_pdu_stream_parser.sv
